[design/m4vt_pkg.sv]
package m4vt_pkg;

  localparam logic [1:0] ACT_WR_STORED  = 2'd0;
  localparam logic [1:0] ACT_WR_OPERAND = 2'd1;
  localparam logic [1:0] ACT_COMPOSE    = 2'd2;
  localparam logic [1:0] ACT_TRANSFORM  = 2'd3;

  localparam int ACC_W = 66;

  typedef struct packed {
    logic [1:0]         action;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic       wr_stored;
    logic       wr_operand;
    logic       load_vec;
    logic       issue;
    logic       compose;
    logic [1:0] c;
    logic [1:0] r;
    logic [1:0] k;
    logic       wr_row;
    logic       load_out;
  } m4vt_cmd_t;

  typedef struct packed {
    logic busy;
  } m4vt_stat_t;

endpackage

[design/m4vt_datapath.sv]
module m4vt_datapath
  import m4vt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  m4vt_cmd_t  cmd,
  output m4vt_stat_t stat,
  output out_item_t  out_data
);

  localparam logic signed [31:0]      ONE_Q = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] MAX_Q = ACC_W'(64'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] MIN_Q = -(ACC_W'(64'sh80000000));

  logic signed [31:0] stored_r  [16];
  logic signed [31:0] operand_r [16];
  logic signed [31:0] vec_r     [4];
  logic signed [31:0] res_r     [4];
  logic               sat_r;
  out_item_t          out_r;

  logic               v1_r, v2_r, v3_r;
  logic               first1_r, first2_r;
  logic               last1_r, last2_r, last3_r;
  logic [1:0]         row1_r, row2_r, row3_r;
  logic signed [31:0] a1_r, b1_r;
  logic signed [63:0] prod2_r;
  logic signed [ACC_W-1:0] acc3_r;

  logic signed [31:0] a_sel, b_sel;
  logic signed [63:0] prod_nxt;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] shifted;
  logic signed [31:0] res_val;
  logic               res_sat;

  always_comb begin
    if (cmd.compose) begin
      a_sel = stored_r[{cmd.c, cmd.k}];
      b_sel = operand_r[{cmd.k, cmd.r}];
    end else begin
      a_sel = vec_r[cmd.k];
      b_sel = stored_r[{cmd.k, cmd.r}];
    end
  end

  assign prod_nxt = a1_r * b1_r;
  assign acc_nxt  = first2_r ? ACC_W'(prod2_r) : acc3_r + ACC_W'(prod2_r);
  assign shifted  = acc3_r >>> FRAC_BITS;

  always_comb begin
    res_sat = 1'b0;
    res_val = shifted[31:0];
    if (shifted > MAX_Q) begin
      res_val = 32'sh7FFFFFFF;
      res_sat = 1'b1;
    end else if (shifted < MIN_Q) begin
      res_val = 32'sh80000000;
      res_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      sat_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        stored_r[i]  <= (i / 4 == i % 4) ? ONE_Q : 32'sd0;
        operand_r[i] <= 32'sd0;
      end
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.wr_stored) begin
        stored_r[in_data.elem_index] <= in_data.elem_value;
      end
      if (cmd.wr_operand) begin
        operand_r[in_data.elem_index] <= in_data.elem_value;
      end
      if (cmd.wr_row) begin
        for (int j = 0; j < 4; j++) begin
          stored_r[{cmd.c, 2'(j)}] <= res_r[j];
        end
      end
      if (cmd.load_vec) begin
        sat_r <= 1'b0;
      end else if (v3_r && last3_r && res_sat) begin
        sat_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vec) begin
      vec_r[0] <= in_data.vec_x;
      vec_r[1] <= in_data.vec_y;
      vec_r[2] <= in_data.vec_z;
      vec_r[3] <= in_data.vec_w;
    end
    a1_r     <= a_sel;
    b1_r     <= b_sel;
    first1_r <= (cmd.k == 2'd0);
    last1_r  <= (cmd.k == 2'd3);
    row1_r   <= cmd.r;
    prod2_r  <= prod_nxt;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    row2_r   <= row1_r;
    if (v2_r) begin
      acc3_r <= acc_nxt;
    end
    last3_r <= last2_r;
    row3_r  <= row2_r;
    if (v3_r && last3_r) begin
      res_r[row3_r] <= res_val;
    end
    if (cmd.load_out) begin
      out_r.out_x     <= res_r[0];
      out_r.out_y     <= res_r[1];
      out_r.out_z     <= res_r[2];
      out_r.out_w     <= res_r[3];
      out_r.saturated <= sat_r;
    end
  end

  assign stat.busy = v1_r | v2_r | v3_r;
  assign out_data  = out_r;

endmodule

[design/m4vt_ctrl.sv]
module m4vt_ctrl
  import m4vt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  output logic       out_valid,
  input  logic       out_ready,
  input  m4vt_stat_t stat,
  output m4vt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROW_WB,
    ST_HOLD
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] c_r, c_nxt;
  logic [1:0] r_r, r_nxt;
  logic [1:0] k_r, k_nxt;
  logic       compose_r, compose_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    c_nxt         = c_r;
    r_nxt         = r_r;
    k_nxt         = k_r;
    compose_nxt   = compose_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.compose   = compose_r;
    cmd.c         = c_r;
    cmd.r         = r_r;
    cmd.k         = k_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_action)
            ACT_WR_STORED:  cmd.wr_stored  = 1'b1;
            ACT_WR_OPERAND: cmd.wr_operand = 1'b1;
            ACT_COMPOSE, ACT_TRANSFORM: begin
              cmd.load_vec = 1'b1;
              compose_nxt  = (in_action == ACT_COMPOSE);
              c_nxt        = 2'd0;
              r_nxt        = 2'd0;
              k_nxt        = 2'd0;
              state_nxt    = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        {r_nxt, k_nxt} = {r_r, k_r} + 4'd1;
        if (r_r == 2'd3 && k_r == 2'd3) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = compose_r ? ST_ROW_WB : ST_HOLD;
        end
      end
      ST_ROW_WB: begin
        cmd.wr_row = 1'b1;
        c_nxt      = c_r + 2'd1;
        state_nxt  = (c_r == 2'd3) ? ST_IDLE : ST_ISSUE;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      c_r         <= 2'd0;
      r_r         <= 2'd0;
      k_r         <= 2'd0;
      compose_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      c_r         <= c_nxt;
      r_r         <= r_nxt;
      k_r         <= k_nxt;
      compose_r   <= compose_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/matrix4_vertex_transform_top.sv]
// 4x4 fixed-point matrix unit: stored transform matrix and operand matrix,
// signed elements with FRAC_BITS fraction bits, index column*4+row.
// Input channel (in_valid/in_ready/in_data) carries one command per transfer:
// write stored element, write operand element, compose, or transform vector.
// Only a transform produces a transfer on the output channel
// (out_valid/out_ready/out_data) with four components and a saturation flag.
// Element writes are taken straight from idle. A transform issues 16 products
// through one shared 32x32 multiply-accumulate pipeline, waits for the
// pipeline to drain and then loads the result. Compose runs the same unit
// over four rows of 16 products, writing each row back into the stored matrix.
// in_ready is high only while the sequencer is idle, so a new command is
// taken only once the previous transform or compose has finished.
// The result sits in an output register; element writes and compose are
// taken while it waits. A further transform completes its arithmetic and
// holds until the receiver takes the previous result.
// Synchronous reset loads the identity into the stored matrix, clears the
// operand matrix and drops out_valid.
module matrix4_vertex_transform_top
  import m4vt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  m4vt_cmd_t  cmd;
  m4vt_stat_t stat;

  m4vt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  m4vt_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

[test/tb_matrix4_vertex_transform_top.sv]
module tb_matrix4_vertex_transform_top;
  import m4vt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 16;
  localparam int ITEM_TARGET = 1550;
  localparam int TAIL_ITEMS  = 120;
  localparam int HOLDOFF     = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN       = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  matrix4_vertex_transform_top #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  logic signed [31:0] stored_m [16];
  logic signed [31:0] operand_m [16];
  in_item_t           pending_items [$];
  out_item_t          expected_vertices [$];
  out_item_t          want_vertex;

  int unsigned errors = 0;
  int unsigned vertices_seen = 0;
  int unsigned composes_seen = 0;
  int unsigned writes_seen = 0;
  int unsigned cmds_accepted = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned holdoff_left = 0;
  int unsigned stuck_cycles = 0;
  bit          holdoff_done = 1'b0;
  bit          tail_phase = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    errors++;
  endtask

  // floor(sum a[i]*b[i] / 2^FRAC), saturated; bit 32 flags the clip
  function automatic logic [32:0] fixed_dot4(input logic [3:0][31:0] a,
                                             input logic [3:0][31:0] b);
    logic signed [67:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) acc = acc + $signed(a[i]) * $signed(b[i]);
    acc = acc >>> FRAC;
    if (acc > 68'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (acc < -68'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, acc[31:0]};
  endfunction

  task automatic apply_command(input in_item_t cmd);
    logic signed [31:0] next_m [16];
    logic [3:0][31:0]   a;
    logic [3:0][31:0]   b;
    logic [3:0][31:0]   comp;
    logic [32:0]        dot;
    logic               clip;
    out_item_t          vtx;
    cmds_accepted++;
    case (cmd.action)
      ACT_WR_STORED: begin
        stored_m[cmd.elem_index] = cmd.elem_value;
        writes_seen++;
      end
      ACT_WR_OPERAND: begin
        operand_m[cmd.elem_index] = cmd.elem_value;
        writes_seen++;
      end
      ACT_COMPOSE: begin
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
              a[k] = stored_m[c * 4 + k];
              b[k] = operand_m[k * 4 + r];
            end
            dot = fixed_dot4(a, b);
            next_m[c * 4 + r] = dot[31:0];
          end
        end
        for (int e = 0; e < 16; e++) stored_m[e] = next_m[e];
        composes_seen++;
      end
      ACT_TRANSFORM: begin
        a[0] = cmd.vec_x;
        a[1] = cmd.vec_y;
        a[2] = cmd.vec_z;
        a[3] = cmd.vec_w;
        clip = 1'b0;
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) b[c] = stored_m[c * 4 + r];
          dot = fixed_dot4(a, b);
          comp[r] = dot[31:0];
          clip = clip | dot[32];
        end
        vtx.out_x = comp[0];
        vtx.out_y = comp[1];
        vtx.out_z = comp[2];
        vtx.out_w = comp[3];
        vtx.saturated = clip;
        expected_vertices.push_back(vtx);
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_q();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      rand_q = $urandom;
    end else if (sel == 1) begin
      case ($urandom_range(0, 3))
        0: rand_q = 32'h7FFF_FFFF;
        1: rand_q = 32'h8000_0000;
        2: rand_q = 32'hFFFF_FFFF;
        default: rand_q = 32'h0001_0000;
      endcase
    end else begin
      rand_q = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    end
  endfunction

  // unused fields carry random junk
  function automatic in_item_t make_cmd(input logic [1:0] act, input logic [3:0] idx,
                                        input logic [31:0] val);
    in_item_t it;
    it.action = act;
    it.elem_index = idx;
    it.elem_value = val;
    it.vec_x = $urandom;
    it.vec_y = $urandom;
    it.vec_z = $urandom;
    it.vec_w = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_vertex(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z, input logic [31:0] w);
    in_item_t it;
    it = make_cmd(ACT_TRANSFORM, 4'($urandom_range(0, 15)), $urandom);
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    it.vec_w = w;
    return it;
  endfunction

  task automatic queue_matrix(input logic [1:0] act);
    for (int e = 0; e < 16; e++)
      pending_items.push_back(make_cmd(act, 4'(e),
        (e % 5 == 0) ? 32'h0001_0000 + rand_q() : rand_q()));
  endtask

  task automatic check_word(input string name, input logic [31:0] got,
                            input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("vertex %0d %s: got %h want %h",
                                vertices_seen, name, got, want));
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) apply_command(in_data);
      tail_phase <= pending_items.size() < TAIL_ITEMS;
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end
      end
    end
  end

  // receiver ready, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else if (!holdoff_done && vertices_seen >= 60) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch($sformatf("vertex transfer with nothing pending: %h", out_data));
      end else begin
        want_vertex = expected_vertices.pop_front();
        check_word("out_x", out_data.out_x, want_vertex.out_x);
        check_word("out_y", out_data.out_y, want_vertex.out_y);
        check_word("out_z", out_data.out_z, want_vertex.out_z);
        check_word("out_w", out_data.out_w, want_vertex.out_w);
        check_word("saturated", 32'(out_data.saturated), 32'(want_vertex.saturated));
      end
      vertices_seen <= vertices_seen + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned kind;
    for (int e = 0; e < 16; e++) begin
      stored_m[e] = (e % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
      operand_m[e] = 32'sh0;
    end

    // identity passes extremes through untouched
    pending_items.push_back(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF));
    pending_items.push_back(make_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000,
                                        32'h8000_0001));
    pending_items.push_back(make_cmd(ACT_WR_STORED, 4'd0, 32'h7FFF_FFFF));
    pending_items.push_back(make_cmd(ACT_WR_STORED, 4'd15, 32'h8000_0000));
    // clip high on x, low on w
    pending_items.push_back(make_vertex(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF));
    pending_items.push_back(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000));
    pending_items.push_back(make_cmd(ACT_WR_OPERAND, 4'd0, 32'h0002_0000));
    pending_items.push_back(make_cmd(ACT_WR_OPERAND, 4'd5, 32'h0000_8000));
    pending_items.push_back(make_cmd(ACT_WR_OPERAND, 4'd10, 32'hFFFF_0000));
    pending_items.push_back(make_cmd(ACT_WR_OPERAND, 4'd15, 32'h7FFF_FFFF));
    pending_items.push_back(make_cmd(ACT_WR_OPERAND, 4'd6, 32'h0001_0000));
    // compose clips silently; all sums come from the old stored matrix
    pending_items.push_back(make_cmd(ACT_COMPOSE, 4'd0, 32'h0));
    pending_items.push_back(make_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                        32'h0001_0000));
    pending_items.push_back(make_vertex(rand_q(), rand_q(), rand_q(), rand_q()));
    pending_items.push_back(make_cmd(ACT_COMPOSE, 4'd15, 32'hFFFF_FFFF));
    pending_items.push_back(make_vertex(32'h0003_4000, 32'hFFFE_8000, 32'h0000_0001,
                                        32'h0001_0000));
    // negative fraction must round toward minus infinity
    pending_items.push_back(make_cmd(ACT_WR_STORED, 4'd5, 32'hFFFF_FFFF));
    pending_items.push_back(make_vertex(32'h0, 32'h0000_8000, 32'h0, 32'h0));
    pending_items.push_back(make_vertex(32'h0, 32'hFFFF_8000, 32'h0, 32'h0));
    pending_items.push_back(make_cmd(ACT_WR_STORED, 4'd0, 32'h0001_0000));
    pending_items.push_back(make_cmd(ACT_WR_STORED, 4'd15, 32'h0001_0000));
    pending_items.push_back(make_vertex(32'hFFFF_FFFF, 32'h1234_5678, 32'hEDCB_A987,
                                        32'h8000_0000));

    while (pending_items.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4))
          pending_items.push_back(make_cmd(2'($urandom_range(0, 3)),
                                           4'($urandom_range(0, 15)), $urandom));
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          queue_matrix(ACT_WR_STORED);
        end else begin
          repeat ($urandom_range(0, 3))
            pending_items.push_back(make_cmd(ACT_WR_STORED, 4'($urandom_range(0, 15)),
                                             rand_q()));
        end
        if ($urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 2) == 0) begin
            queue_matrix(ACT_WR_OPERAND);
          end else begin
            repeat ($urandom_range(1, 6))
              pending_items.push_back(make_cmd(ACT_WR_OPERAND, 4'($urandom_range(0, 15)),
                                               rand_q()));
          end
          repeat ($urandom_range(1, 2))
            pending_items.push_back(make_cmd(ACT_COMPOSE, 4'($urandom_range(0, 15)),
                                             $urandom));
        end
        repeat ($urandom_range(2, 16))
          pending_items.push_back(make_vertex(rand_q(), rand_q(), rand_q(), rand_q()));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d commands taken: %0d element writes, %0d composes, %0d vertices checked",
             cmds_accepted, writes_seen, composes_seen, vertices_seen);
    $display("errors counted: %0d", errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
design/m4vt_pkg.sv
design/m4vt_datapath.sv
design/m4vt_ctrl.sv
design/matrix4_vertex_transform_top.sv
test/tb_matrix4_vertex_transform_top.sv
